FILE: sv/rasr_pkg.sv
// Package with types, codes and constants for the rational add/subtract/reduce unit.
package rasr_pkg;

   localparam int DEF_WIDTH = 32;

   localparam logic [1:0] FUNC_ADD    = 2'd0;
   localparam logic [1:0] FUNC_SUB    = 2'd1;
   localparam logic [1:0] FUNC_CMP    = 2'd2;
   localparam logic [1:0] FUNC_REDUCE = 2'd3;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_ZERO = 2'd1;
   localparam logic [1:0] STATUS_OVF  = 2'd2;

   typedef struct packed {
      logic [1:0]   func;
      logic [31:0]  a_num;
      logic [31:0]  a_den;
      logic [31:0]  b_num;
      logic [31:0]  b_den;
   } req_type;

   typedef struct packed {
      logic [31:0]  res_num;
      logic [30:0]  res_den;
      logic [31:0]  whole_part;
      logic [31:0]  frac_num;
      logic         less;
      logic         greater;
      logic [1:0]   status;
   } rsp_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_GCD_DEN,
      CMD_GCD_RES,
      CMD_DIV_ADM,
      CMD_DIV_BDM,
      CMD_DIV_MAG,
      CMD_DIV_L,
      CMD_DIV_ND,
      CMD_ST_P,
      CMD_ST_Q,
      CMD_ST_N,
      CMD_ST_D,
      CMD_ST_WR,
      CMD_MUL_L,
      CMD_MUL_MA,
      CMD_MUL_MB,
      CMD_MUL_CA,
      CMD_MUL_CB,
      CMD_COMBINE,
      CMD_SETUP_RED,
      CMD_FIN_ERR,
      CMD_FIN_OVF,
      CMD_FIN_CMP,
      CMD_FIN_ARITH
   } cmd_type;

   typedef struct packed {
      logic [1:0]  func;
      logic        zero_err;
      logic        gcd_busy;
      logic        div_busy;
      logic        ovf;
   } stat_type;

endpackage

FILE: sv/rational_add_sub_reduce_unit.sv
// Top level of the rational add, subtract, compare and reduce unit.
// A request is taken at a rising edge with start high and busy low. The
// request carries an operation code and two signed fractions. Busy stays
// high while the request is worked on, and exactly one result follows on
// rsp_data for a single cycle with rsp_valid high.
// The result shows in the cycle right after busy falls, and a new request
// can be taken at the edge that ends that cycle. A zero denominator ends
// the request at the check, and compare runs no gcd or division. Add and
// subtract wait on two binary gcd runs, one on the 32-bit denominators and
// one on the 64-bit magnitude and common denominator, and reduce waits on
// one gcd run. An overflow ends the request before the last division.
// The receiver cannot stall the block, so a result is shown once and never
// held. A synchronous reset returns the controller to idle and drops any
// request in progress; no result is given for it.
module rational_add_sub_reduce_unit
   import rasr_pkg::*;
#(
   parameter int WIDTH = DEF_WIDTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   rasr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   rasr_datapath #(
      .WIDTH (WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: sv/rasr_ctrl.sv
// Controller state machine that sequences the datapath for each request.
module rasr_ctrl
   import rasr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy
);

   typedef enum logic [4:0] {
      S_IDLE, S_CHK, S_CMPB, S_CMPF, S_W1, S_W2, S_D2, S_W3, S_M1, S_M2, S_M3,
      S_CB, S_G2, S_W4, S_W5, S_D4, S_W6, S_CK, S_W7, S_FA
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd      = CMD_LOAD;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (stat.zero_err) begin
               cmd      = CMD_FIN_ERR;
               state_in = S_IDLE;
            end else if (stat.func == FUNC_CMP) begin
               cmd      = CMD_MUL_CA;
               state_in = S_CMPB;
            end else if (stat.func == FUNC_REDUCE) begin
               cmd      = CMD_SETUP_RED;
               state_in = S_G2;
            end else begin
               cmd      = CMD_GCD_DEN;
               state_in = S_W1;
            end
         end
         S_CMPB: begin
            cmd      = CMD_MUL_CB;
            state_in = S_CMPF;
         end
         S_CMPF: begin
            cmd      = CMD_FIN_CMP;
            state_in = S_IDLE;
         end
         S_W1: begin
            if (!stat.gcd_busy) begin
               cmd      = CMD_DIV_ADM;
               state_in = S_W2;
            end
         end
         S_W2: begin
            if (!stat.div_busy) begin
               cmd      = CMD_ST_P;
               state_in = S_D2;
            end
         end
         S_D2: begin
            cmd      = CMD_DIV_BDM;
            state_in = S_W3;
         end
         S_W3: begin
            if (!stat.div_busy) begin
               cmd      = CMD_ST_Q;
               state_in = S_M1;
            end
         end
         S_M1: begin
            cmd      = CMD_MUL_L;
            state_in = S_M2;
         end
         S_M2: begin
            cmd      = CMD_MUL_MA;
            state_in = S_M3;
         end
         S_M3: begin
            cmd      = CMD_MUL_MB;
            state_in = S_CB;
         end
         S_CB: begin
            cmd      = CMD_COMBINE;
            state_in = S_G2;
         end
         S_G2: begin
            cmd      = CMD_GCD_RES;
            state_in = S_W4;
         end
         S_W4: begin
            if (!stat.gcd_busy) begin
               cmd      = CMD_DIV_MAG;
               state_in = S_W5;
            end
         end
         S_W5: begin
            if (!stat.div_busy) begin
               cmd      = CMD_ST_N;
               state_in = S_D4;
            end
         end
         S_D4: begin
            cmd      = CMD_DIV_L;
            state_in = S_W6;
         end
         S_W6: begin
            if (!stat.div_busy) begin
               cmd      = CMD_ST_D;
               state_in = S_CK;
            end
         end
         S_CK: begin
            if (stat.ovf) begin
               cmd      = CMD_FIN_OVF;
               state_in = S_IDLE;
            end else begin
               cmd      = CMD_DIV_ND;
               state_in = S_W7;
            end
         end
         S_W7: begin
            if (!stat.div_busy) begin
               cmd      = CMD_ST_WR;
               state_in = S_FA;
            end
         end
         S_FA: begin
            cmd      = CMD_FIN_ARITH;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

FILE: sv/rasr_datapath.sv
// Datapath with operand registers, a shared multiplier, a binary gcd unit and a divider.
module rasr_datapath
   import rasr_pkg::*;
#(
   parameter int WIDTH = DEF_WIDTH
)
(
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   input  req_type  req_data,
   output stat_type stat,
   output logic     rsp_valid,
   output rsp_type  rsp_data
);

   localparam int RES_W = (WIDTH < 2) ? 2 : ((WIDTH < 32) ? WIDTH : 32);
   localparam logic [63:0] LIM = 64'd1 << (RES_W - 1);

   logic [1:0]  func_ff;
   logic [31:0] anm_ff, adm_ff, bnm_ff, bdm_ff;
   logic        ans_ff, ads_ff, bns_ff, bds_ff;
   logic [31:0] p_ff, q_ff;
   logic [63:0] l_ff, ma_ff, mb_ff, mag_ff, n_ff, d_ff;
   logic        neg_ff;
   logic [31:0] whole_ff, rem_ff;
   logic        valid_ff;
   rsp_type     rsp_ff, rsp_in;

   // gcd unit
   logic [63:0] gu_ff, gv_ff, g_ff;
   logic [6:0]  gk_ff;
   logic        gbusy_ff;

   // divider unit
   logic [63:0] dr_ff, dq_ff, ds_ff;
   logic [6:0]  dc_ff;
   logic        dbusy_ff;

   function automatic logic [31:0] mag32(input logic [31:0] x);
      return x[31] ? (32'd0 - x) : x;
   endfunction

   function automatic logic [31:0] sgn32(input logic neg, input logic [31:0] x);
      return neg ? (32'd0 - x) : x;
   endfunction

   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   always_comb begin
      mul_a = p_ff;
      mul_b = bdm_ff;
      case (cmd)
         CMD_MUL_MA: begin
            mul_a = anm_ff;
            mul_b = q_ff;
         end
         CMD_MUL_MB: begin
            mul_a = bnm_ff;
            mul_b = p_ff;
         end
         CMD_MUL_CA: begin
            mul_a = anm_ff;
            mul_b = bdm_ff;
         end
         CMD_MUL_CB: begin
            mul_a = bnm_ff;
            mul_b = adm_ff;
         end
         default: begin
            mul_a = p_ff;
            mul_b = bdm_ff;
         end
      endcase
   end
   assign prod = {32'd0, mul_a} * {32'd0, mul_b};

   logic na, nb;
   assign na = (ans_ff ^ ads_ff) && (ma_ff != 64'd0);
   assign nb = (bns_ff ^ bds_ff ^ (func_ff == FUNC_SUB)) && (mb_ff != 64'd0);

   logic signed [64:0] lv, rv;
   assign lv = na ? -$signed({1'b0, ma_ff}) : $signed({1'b0, ma_ff});
   assign rv = nb ? -$signed({1'b0, mb_ff}) : $signed({1'b0, mb_ff});

   logic negn;
   assign negn = neg_ff && (n_ff != 64'd0);

   // gcd step
   logic        g_end;
   logic [63:0] g_diff_uv, g_diff_vu;
   assign g_end     = (gu_ff == gv_ff) || (gu_ff == 64'd0) || (gv_ff == 64'd0);
   assign g_diff_uv = gu_ff - gv_ff;
   assign g_diff_vu = gv_ff - gu_ff;

   // divider step
   logic [64:0] dt;
   logic        dge;
   assign dt  = {dr_ff, dq_ff[63]};
   assign dge = (dt >= {1'b0, ds_ff});

   logic        div_go, div_32;
   logic [63:0] div_x, div_s;
   always_comb begin
      div_go = 1'b1;
      div_32 = 1'b1;
      div_x  = {32'd0, adm_ff};
      div_s  = g_ff;
      case (cmd)
         CMD_DIV_ADM: begin
            div_x = {32'd0, adm_ff};
         end
         CMD_DIV_BDM: begin
            div_x = {32'd0, bdm_ff};
         end
         CMD_DIV_MAG: begin
            div_x  = mag_ff;
            div_32 = 1'b0;
         end
         CMD_DIV_L: begin
            div_x  = l_ff;
            div_32 = 1'b0;
         end
         CMD_DIV_ND: begin
            div_x = {32'd0, n_ff[31:0]};
            div_s = d_ff;
         end
         default: begin
            div_go = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_in = rsp_ff;
      case (cmd)
         CMD_FIN_ERR: begin
            rsp_in        = '0;
            rsp_in.status = STATUS_ZERO;
         end
         CMD_FIN_OVF: begin
            rsp_in        = '0;
            rsp_in.status = STATUS_OVF;
         end
         CMD_FIN_CMP: begin
            rsp_in         = '0;
            rsp_in.less    = (lv < rv);
            rsp_in.greater = (lv > rv);
            rsp_in.status  = STATUS_OK;
         end
         CMD_FIN_ARITH: begin
            rsp_in.res_num    = sgn32(negn, n_ff[31:0]);
            rsp_in.res_den    = d_ff[30:0];
            rsp_in.whole_part = sgn32(negn, whole_ff);
            rsp_in.frac_num   = sgn32(negn, rem_ff);
            rsp_in.less       = 1'b0;
            rsp_in.greater    = 1'b0;
            rsp_in.status     = STATUS_OK;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gbusy_ff <= 1'b0;
         dbusy_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= (cmd == CMD_FIN_ERR) || (cmd == CMD_FIN_OVF) ||
                     (cmd == CMD_FIN_CMP) || (cmd == CMD_FIN_ARITH);
         if ((cmd == CMD_GCD_DEN) || (cmd == CMD_GCD_RES)) begin
            gbusy_ff <= 1'b1;
         end else if (gbusy_ff && g_end) begin
            gbusy_ff <= 1'b0;
         end
         if (div_go) begin
            dbusy_ff <= 1'b1;
         end else if (dbusy_ff && (dc_ff == 7'd1)) begin
            dbusy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd == CMD_GCD_DEN) begin
         gu_ff <= {32'd0, adm_ff};
         gv_ff <= {32'd0, bdm_ff};
         gk_ff <= 7'd0;
      end else if (cmd == CMD_GCD_RES) begin
         gu_ff <= mag_ff;
         gv_ff <= l_ff;
         gk_ff <= 7'd0;
      end else if (gbusy_ff) begin
         if (g_end) begin
            g_ff <= ((gu_ff == 64'd0) ? gv_ff : gu_ff) << gk_ff;
         end else if (!gu_ff[0] && !gv_ff[0]) begin
            gu_ff <= gu_ff >> 1;
            gv_ff <= gv_ff >> 1;
            gk_ff <= gk_ff + 7'd1;
         end else if (!gu_ff[0]) begin
            gu_ff <= gu_ff >> 1;
         end else if (!gv_ff[0]) begin
            gv_ff <= gv_ff >> 1;
         end else if (gu_ff > gv_ff) begin
            gu_ff <= g_diff_uv >> 1;
         end else begin
            gv_ff <= g_diff_vu >> 1;
         end
      end

      if (div_go) begin
         dr_ff <= 64'd0;
         dq_ff <= div_32 ? {div_x[31:0], 32'd0} : div_x;
         ds_ff <= div_s;
         dc_ff <= div_32 ? 7'd32 : 7'd64;
      end else if (dbusy_ff) begin
         dr_ff <= dge ? (dt[63:0] - ds_ff) : dt[63:0];
         dq_ff <= {dq_ff[62:0], dge};
         dc_ff <= dc_ff - 7'd1;
      end

      rsp_ff <= rsp_in;

      case (cmd)
         CMD_LOAD: begin
            func_ff <= req_data.func;
            anm_ff  <= mag32(req_data.a_num);
            adm_ff  <= mag32(req_data.a_den);
            bnm_ff  <= mag32(req_data.b_num);
            bdm_ff  <= mag32(req_data.b_den);
            ans_ff  <= req_data.a_num[31];
            ads_ff  <= req_data.a_den[31];
            bns_ff  <= req_data.b_num[31];
            bds_ff  <= req_data.b_den[31];
         end
         CMD_ST_P: p_ff <= dq_ff[31:0];
         CMD_ST_Q: q_ff <= dq_ff[31:0];
         CMD_ST_N: n_ff <= dq_ff;
         CMD_ST_D: d_ff <= dq_ff;
         CMD_ST_WR: begin
            whole_ff <= dq_ff[31:0];
            rem_ff   <= dr_ff[31:0];
         end
         CMD_MUL_L:  l_ff  <= prod;
         CMD_MUL_MA: ma_ff <= prod;
         CMD_MUL_MB: mb_ff <= prod;
         CMD_MUL_CA: ma_ff <= prod;
         CMD_MUL_CB: mb_ff <= prod;
         CMD_COMBINE: begin
            if (na == nb) begin
               mag_ff <= ma_ff + mb_ff;
               neg_ff <= na;
            end else if (ma_ff >= mb_ff) begin
               mag_ff <= ma_ff - mb_ff;
               neg_ff <= na;
            end else begin
               mag_ff <= mb_ff - ma_ff;
               neg_ff <= nb;
            end
         end
         CMD_SETUP_RED: begin
            mag_ff <= {32'd0, anm_ff};
            l_ff   <= {32'd0, adm_ff};
            neg_ff <= ans_ff ^ ads_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      stat.func     = func_ff;
      stat.zero_err = (adm_ff == 32'd0) || ((func_ff != FUNC_REDUCE) && (bdm_ff == 32'd0));
      stat.gcd_busy = gbusy_ff;
      stat.div_busy = dbusy_ff;
      stat.ovf      = (negn ? (n_ff > LIM) : (n_ff > LIM - 64'd1)) || (d_ff > LIM - 64'd1);
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
